### src/csrw_pkg.sv
// ----------------------------------------------------------------------------
// csrw_pkg
// Shared types and constants for the cube shell region walker.
// ----------------------------------------------------------------------------
package csrw_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int RAD_BITS       = 15;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic [RAD_BITS-1:0] RADIUS_LIMIT_RST = RAD_BITS'(16);

    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_NEXT    = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WMIN_X  = 3'd0,
        CFG_WMIN_Y  = 3'd1,
        CFG_WMIN_Z  = 3'd2,
        CFG_WMAX_X  = 3'd3,
        CFG_WMAX_Y  = 3'd4,
        CFG_WMAX_Z  = 3'd5,
        CFG_RLIMIT  = 3'd6
    } t_cfg_idx;

    // outcome of one walk step
    typedef enum logic [1:0] {
        DEC_FAIL = 2'd0,
        DEC_ADV  = 2'd1,
        DEC_RAD  = 2'd2,
        DEC_EMIT = 2'd3
    } t_dec;

    typedef struct packed {
        logic start;
        logic bnd1;
        logic bnd2;
        logic step;
        logic out_load;
        logic out_found;
    } t_cmd;

    typedef struct packed {
        t_dec dec;
        logic out_free;
    } t_stat;

endpackage

### src/cube_shell_region_walker.sv
// ----------------------------------------------------------------------------
// cube_shell_region_walker
// Walks the cells on the surface of a growing cube around a centre cell,
// clamped to a configured world box.
// ----------------------------------------------------------------------------
// A restart word (mode 0) stores the centre and returns a word with found 0
// once the result register is free. A next word (mode 1) returns the next
// shell cell after cube bound setup and the final step, with a further walk
// step for each row or plane advance or interior skip, and a growth step and
// a fresh bound setup each time the radius grows; all of this runs through
// one cursor update unit that makes one walk step per cycle while no bound
// setup runs. The final step waits while the result register
// still holds an unread word. Words are taken one at a time, and a result
// register lets the next word be taken while a result still waits.
// Configuration writes are always taken and go straight into the box and
// limit registers.
module cube_shell_region_walker import csrw_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int CFG_BITS  = (COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_BITS-1:0]          i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic signed [COORD_BITS-1:0] i_center_z,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_found,
    output logic signed [COORD_BITS-1:0] o_cell_x,
    output logic signed [COORD_BITS-1:0] o_cell_y,
    output logic signed [COORD_BITS-1:0] o_cell_z
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    csrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    csrw_dp #(
        .COORD_BITS (COORD_BITS),
        .CFG_BITS   (CFG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_cell_x    (o_cell_x),
        .o_cell_y    (o_cell_y),
        .o_cell_z    (o_cell_z)
    );

endmodule

### src/csrw_dp.sv
// ----------------------------------------------------------------------------
// csrw_dp
// Datapath: world box registers, centre, cursor and radius, per-radius cube
// bounds, one walk step per cycle while stepping is commanded, and the result register.
// ----------------------------------------------------------------------------
module csrw_dp import csrw_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CFG_BITS   = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_BITS-1:0]          i_cfg_data,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic signed [COORD_BITS-1:0] i_center_z,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_found,
    output logic signed [COORD_BITS-1:0] o_cell_x,
    output logic signed [COORD_BITS-1:0] o_cell_y,
    output logic signed [COORD_BITS-1:0] o_cell_z
);

    localparam int RW = RAD_BITS + 1;
    localparam int WB = ((COORD_BITS > RW) ? COORD_BITS : RW) + 2;
    localparam logic signed [WB-1:0] ONE = WB'(1);

    // configuration
    logic signed [COORD_BITS-1:0] r_wmin_x, r_wmin_y, r_wmin_z;
    logic signed [COORD_BITS-1:0] r_wmax_x, r_wmax_y, r_wmax_z;
    logic [RAD_BITS-1:0]          r_rlimit;

    // walk state
    logic                         r_started;
    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_cz;
    logic signed [WB-1:0]         r_ux, r_uy, r_uz;
    logic [RW-1:0]                r_radius;

    // cube bounds for the current radius
    logic signed [WB-1:0] r_lo_x, r_lo_y, r_lo_z, r_hi_x, r_hi_y, r_hi_z;
    logic signed [WB-1:0] r_a0_x, r_a0_y, r_a0_z, r_a1_x, r_a1_y, r_a1_z;
    logic signed [WB-1:0] r_skip_x, r_skip_y, r_skip_z;
    logic                 r_skgt_x, r_skgt_z;
    logic                 r_outside, r_covers, r_yclip, r_zclip;

    // result register
    logic                         r_out_valid, r_found;
    logic signed [COORD_BITS-1:0] r_cell_x, r_cell_y, r_cell_z;

    logic signed [WB-1:0] wmin_x, wmin_y, wmin_z, wmax_x, wmax_y, wmax_z;
    logic signed [WB-1:0] rad_e;
    logic lt_x, lt_y, lt_z, gt_x, gt_y, gt_z;
    logic inx, inz, rad_over, fail, interior;
    logic y_wrap, zs_cond, z_wrap, xs_cond, x_wrap;
    logic signed [WB-1:0] nz, z1, nx, x2, lm1_x, lm1_y, lm1_z;
    t_dec dec;

    assign wmin_x = WB'(r_wmin_x);
    assign wmin_y = WB'(r_wmin_y);
    assign wmin_z = WB'(r_wmin_z);
    assign wmax_x = WB'(r_wmax_x);
    assign wmax_y = WB'(r_wmax_y);
    assign wmax_z = WB'(r_wmax_z);
    assign rad_e  = $signed(WB'(r_radius));

    assign lt_x = r_lo_x < wmin_x;
    assign lt_y = r_lo_y < wmin_y;
    assign lt_z = r_lo_z < wmin_z;
    assign gt_x = r_hi_x > wmax_x;
    assign gt_y = r_hi_y > wmax_y;
    assign gt_z = r_hi_z > wmax_z;

    always_comb begin
        inx      = (r_ux > r_lo_x) && (r_ux < r_hi_x);
        inz      = (r_uz > r_lo_z) && (r_uz < r_hi_z);
        rad_over = r_radius > {1'b0, r_rlimit};
        fail     = !r_started || r_outside || rad_over || r_covers;
        interior = inx && inz && (r_uy > r_lo_y) && (r_uy < r_hi_y);
        y_wrap   = r_uy > r_a1_y;

        // pass rows of interior cells in one move
        nz      = r_uz + ONE;
        zs_cond = inx && r_yclip && (nz > r_lo_z) && (nz < r_hi_z) && (nz <= r_a1_z);
        z1      = zs_cond ? r_skip_z : nz;
        z_wrap  = zs_cond ? r_skgt_z : (nz > r_a1_z);

        // pass whole planes of interior cells in one move
        nx      = r_ux + ONE;
        xs_cond = (nx <= r_a1_x) && (nx > r_lo_x) && (nx < r_hi_x) && r_yclip && r_zclip;
        x2      = xs_cond ? r_skip_x : nx;
        x_wrap  = xs_cond ? r_skgt_x : (nx > r_a1_x);

        lm1_x = r_lo_x - ONE;
        lm1_y = r_lo_y - ONE;
        lm1_z = r_lo_z - ONE;

        if (fail) begin
            dec = DEC_FAIL;
        end else if (y_wrap && z_wrap && x_wrap) begin
            dec = DEC_RAD;
        end else if (y_wrap || interior) begin
            dec = DEC_ADV;
        end else begin
            dec = DEC_EMIT;
        end
    end

    assign o_stat.dec      = dec;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wmin_x <= '0;
            r_wmin_y <= '0;
            r_wmin_z <= '0;
            r_wmax_x <= '0;
            r_wmax_y <= '0;
            r_wmax_z <= '0;
            r_rlimit <= RADIUS_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WMIN_X: r_wmin_x <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_WMIN_Y: r_wmin_y <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_WMIN_Z: r_wmin_z <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_WMAX_X: r_wmax_x <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_WMAX_Y: r_wmax_y <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_WMAX_Z: r_wmax_z <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_RLIMIT: r_rlimit <= i_cfg_data[RAD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (i_cmd.start) begin
            r_started <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_cz     <= i_center_z;
            r_ux     <= WB'(i_center_x);
            r_uy     <= WB'(i_center_y);
            r_uz     <= WB'(i_center_z);
            r_radius <= '0;
        end else if (i_cmd.step) begin
            case (dec)
                DEC_ADV: begin
                    if (y_wrap) begin
                        r_uy <= r_a0_y;
                        if (z_wrap) begin
                            r_uz <= r_a0_z;
                            r_ux <= x2;
                        end else begin
                            r_uz <= z1;
                        end
                    end else begin
                        r_uy <= r_skip_y;
                    end
                end
                DEC_RAD: begin
                    r_radius <= r_radius + 1'b1;
                    r_ux     <= (lm1_x > wmin_x) ? lm1_x : wmin_x;
                    r_uy     <= (lm1_y > wmin_y) ? lm1_y : wmin_y;
                    r_uz     <= (lm1_z > wmin_z) ? lm1_z : wmin_z;
                end
                DEC_EMIT: r_uy <= r_uy + ONE;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bnd1) begin
            r_lo_x    <= WB'(r_cx) - rad_e;
            r_lo_y    <= WB'(r_cy) - rad_e;
            r_lo_z    <= WB'(r_cz) - rad_e;
            r_hi_x    <= WB'(r_cx) + rad_e;
            r_hi_y    <= WB'(r_cy) + rad_e;
            r_hi_z    <= WB'(r_cz) + rad_e;
            r_outside <= (r_cx > r_wmax_x) || (r_cy > r_wmax_y) || (r_cz > r_wmax_z) ||
                         (r_cx < r_wmin_x) || (r_cy < r_wmin_y) || (r_cz < r_wmin_z);
        end
        if (i_cmd.bnd2) begin
            r_a0_x   <= lt_x ? wmin_x : r_lo_x;
            r_a0_y   <= lt_y ? wmin_y : r_lo_y;
            r_a0_z   <= lt_z ? wmin_z : r_lo_z;
            r_a1_x   <= gt_x ? wmax_x : r_hi_x;
            r_a1_y   <= gt_y ? wmax_y : r_hi_y;
            r_a1_z   <= gt_z ? wmax_z : r_hi_z;
            // first cell past the clamped run of interior cells
            r_skip_x <= gt_x ? (wmax_x + ONE) : r_hi_x;
            r_skip_y <= gt_y ? (wmax_y + ONE) : r_hi_y;
            r_skip_z <= gt_z ? (wmax_z + ONE) : r_hi_z;
            r_skgt_x <= gt_x;
            r_skgt_z <= gt_z;
            r_yclip  <= lt_y && gt_y;
            r_zclip  <= lt_z && gt_z;
            r_covers <= lt_x && lt_y && lt_z && gt_x && gt_y && gt_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found  <= i_cmd.out_found;
            r_cell_x <= i_cmd.out_found ? r_ux[COORD_BITS-1:0] : '0;
            r_cell_y <= i_cmd.out_found ? r_uy[COORD_BITS-1:0] : '0;
            r_cell_z <= i_cmd.out_found ? r_uz[COORD_BITS-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_cell_x    = r_cell_x;
    assign o_cell_y    = r_cell_y;
    assign o_cell_z    = r_cell_z;

endmodule

### src/csrw_ctrl.sv
// ----------------------------------------------------------------------------
// csrw_ctrl
// Controller: accepts words, sequences bound setup and walk steps, and hands
// the outcome to the result register.
// ----------------------------------------------------------------------------
module csrw_ctrl import csrw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_mode,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_REST = 5'b00010,
        S_BND1 = 5'b00100,
        S_BND2 = 5'b01000,
        S_STEP = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_RESTART) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_REST;
                    end else begin
                        n_state = S_BND1;
                    end
                end
            end
            S_REST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_BND1: begin
                o_cmd.bnd1 = 1'b1;
                n_state    = S_BND2;
            end
            S_BND2: begin
                o_cmd.bnd2 = 1'b1;
                n_state    = S_STEP;
            end
            S_STEP: begin
                unique case (i_stat.dec)
                    DEC_ADV: o_cmd.step = 1'b1;
                    DEC_RAD: begin
                        o_cmd.step = 1'b1;
                        n_state    = S_BND1;
                    end
                    default: begin
                        // hold the decision until the result register frees up
                        if (i_stat.out_free) begin
                            o_cmd.step      = 1'b1;
                            o_cmd.out_load  = 1'b1;
                            o_cmd.out_found = (i_stat.dec == DEC_EMIT);
                            n_state         = S_IDLE;
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/csrw_checker.sv
// ----------------------------------------------------------------------------
// csrw_checker
// Port-level checks on the walker, bound to the top level.
// ----------------------------------------------------------------------------
module csrw_checker import csrw_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_found,
    input logic [COORD_BITS-1:0] o_cell_x,
    input logic [COORD_BITS-1:0] o_cell_y,
    input logic [COORD_BITS-1:0] o_cell_z
);

    // a word with no cell carries zero coordinates
    a_nofound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_cell_x == '0 && o_cell_y == '0 && o_cell_z == '0)
        else $error("cell fields not zero while found is low");

    // input ready is low in the cycle after a word is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a word was taken");

    // a result only shows up while a word is in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared with no word in work");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found) &&
        $stable(o_cell_x) && $stable(o_cell_y) && $stable(o_cell_z))
        else $error("stalled result changed");

endmodule

bind cube_shell_region_walker csrw_checker #(
    .COORD_BITS (COORD_BITS)
) u_csrw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_found     (o_found),
    .o_cell_x    (o_cell_x),
    .o_cell_y    (o_cell_y),
    .o_cell_z    (o_cell_z)
);

### tb/cube_shell_region_walker_tb.sv
// ----------------------------------------------------------------------------
// cube_shell_region_walker_tb
// Self-checking bench for the cube shell region walker. Restart and next
// words go in through a queue-fed driver. A shell walk predictor computes the
// expected cell for every word taken. A monitor checks each result word
// against the oldest prediction. The world box and the radius limit are
// reprogrammed between phases. This covers small random boxes, boxes at both
// corners of the coordinate range and the full range. The sender and receiver
// stall at random, and the receiver makes one long hold-off.
// ----------------------------------------------------------------------------
module cube_shell_region_walker_tb;
    import csrw_pkg::*;

    localparam int CRD         = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int WORDS_PER_SETTING = 85;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd7;
    localparam longint CRD_MIN = -(longint'(1) << (CRD - 1));
    localparam longint CRD_MAX = (longint'(1) << (CRD - 1)) - 1;

    typedef struct packed {
        logic                  mode;
        logic [CRD-1:0]        cx;
        logic [CRD-1:0]        cy;
        logic [CRD-1:0]        cz;
    } t_walk_req;

    typedef struct packed {
        logic                  found;
        logic [CRD-1:0]        x;
        logic [CRD-1:0]        y;
        logic [CRD-1:0]        z;
    } t_shell_cell;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CRD-1:0]        i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode      = MODE_RESTART;
    logic signed [CRD-1:0] i_center_x  = '0;
    logic signed [CRD-1:0] i_center_y  = '0;
    logic signed [CRD-1:0] i_center_z  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic signed [CRD-1:0] o_cell_x;
    logic signed [CRD-1:0] o_cell_y;
    logic signed [CRD-1:0] o_cell_z;

    cube_shell_region_walker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_cell_x    (o_cell_x),
        .o_cell_y    (o_cell_y),
        .o_cell_z    (o_cell_z)
    );

    t_walk_req   walk_req_q[$];
    t_shell_cell cell_expect_q[$];
    t_walk_req   drive_word;
    t_shell_cell want_cell;

    int          err_cnt       = 0;
    int          cycle_cnt     = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asked    = 0;
    int          hold_taken    = 0;
    int          hold_left     = 0;

    // walker image: world box, limit and walk state
    longint box_lo_x, box_lo_y, box_lo_z;
    longint box_hi_x, box_hi_y, box_hi_z;
    longint rad_max;
    bit     walk_started;
    longint ctr_x, ctr_y, ctr_z;
    longint cur_x, cur_y, cur_z;
    longint rad;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic void reset_walker();
        box_lo_x = 0; box_lo_y = 0; box_lo_z = 0;
        box_hi_x = 0; box_hi_y = 0; box_hi_z = 0;
        rad_max = longint'(RADIUS_LIMIT_RST);
        walk_started = 1'b0;
        ctr_x = 0; ctr_y = 0; ctr_z = 0;
        cur_x = 0; cur_y = 0; cur_z = 0;
        rad = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CRD-1:0] data);
        longint sv;
        sv = longint'($signed(data));
        case (t_cfg_idx'(idx))
            CFG_WMIN_X: box_lo_x = sv;
            CFG_WMIN_Y: box_lo_y = sv;
            CFG_WMIN_Z: box_lo_z = sv;
            CFG_WMAX_X: box_hi_x = sv;
            CFG_WMAX_Y: box_hi_y = sv;
            CFG_WMAX_Z: box_hi_z = sv;
            CFG_RLIMIT: rad_max  = longint'(data[RAD_BITS-1:0]);
            default: ;
        endcase
    endfunction

    // advance the shell walk by one word and return the cell it yields
    function automatic t_shell_cell next_shell_cell(t_walk_req req);
        longint r, lox, loy, loz, hix, hiy, hiz;
        longint ax0, ay0, az0, ax1, ay1, az1, nz;
        bit inx, inz, yclip;
        t_shell_cell res;
        res = '0;
        if (req.mode == MODE_RESTART) begin
            walk_started = 1'b1;
            ctr_x = longint'($signed(req.cx));
            ctr_y = longint'($signed(req.cy));
            ctr_z = longint'($signed(req.cz));
            cur_x = ctr_x;
            cur_y = ctr_y;
            cur_z = ctr_z;
            rad = 0;
            return res;
        end
        if (!walk_started)
            return res;
        if (ctr_x > box_hi_x || ctr_y > box_hi_y || ctr_z > box_hi_z ||
            ctr_x < box_lo_x || ctr_y < box_lo_y || ctr_z < box_lo_z)
            return res;
        while (rad <= rad_max) begin
            r = rad;
            lox = ctr_x - r; loy = ctr_y - r; loz = ctr_z - r;
            hix = ctr_x + r; hiy = ctr_y + r; hiz = ctr_z + r;
            if (lox < box_lo_x && loy < box_lo_y && loz < box_lo_z &&
                hix > box_hi_x && hiy > box_hi_y && hiz > box_hi_z)
                return res;
            ax0 = lmax(lox, box_lo_x); ax1 = lmin(hix, box_hi_x);
            ay0 = lmax(loy, box_lo_y); ay1 = lmin(hiy, box_hi_y);
            az0 = lmax(loz, box_lo_z); az1 = lmin(hiz, box_hi_z);
            inx = cur_x > lox && cur_x < hix;
            inz = cur_z > loz && cur_z < hiz;
            yclip = ay0 > loy && ay1 < hiy;
            if (cur_y > ay1) begin
                nz = cur_z + 1;
                cur_y = ay0;
                // pass a whole interior row at once
                if (inx && yclip && nz > loz && nz < hiz && nz <= az1)
                    cur_z = lmin(hiz, az1 + 1);
                else
                    cur_z = nz;
                if (cur_z > az1) begin
                    cur_z = az0;
                    cur_x = cur_x + 1;
                    // pass a whole interior x plane at once
                    if (cur_x <= ax1 && cur_x > lox && cur_x < hix &&
                        yclip && az0 > loz && az1 < hiz)
                        cur_x = lmin(hix, ax1 + 1);
                    if (cur_x > ax1) begin
                        rad = rad + 1;
                        cur_x = lmax(ctr_x - rad, box_lo_x);
                        cur_y = lmax(ctr_y - rad, box_lo_y);
                        cur_z = lmax(ctr_z - rad, box_lo_z);
                    end
                end
                continue;
            end
            if (inx && inz && cur_y > loy && cur_y < hiy) begin
                cur_y = (ay1 < hiy) ? ay1 + 1 : hiy;
                continue;
            end
            res.found = 1'b1;
            res.x = cur_x[CRD-1:0];
            res.y = cur_y[CRD-1:0];
            res.z = cur_z[CRD-1:0];
            cur_y = cur_y + 1;
            return res;
        end
        return res;
    endfunction

    // driver: hold a word until taken, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                cell_expect_q.insert(cell_expect_q.size(),
                                     next_shell_cell({i_mode, i_center_x,
                                                      i_center_y, i_center_z}));
            if (!i_in_valid || o_in_ready) begin
                if (walk_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_word = walk_req_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode     <= drive_word.mode;
                    i_center_x <= drive_word.cx;
                    i_center_y <= drive_word.cy;
                    i_center_z <= drive_word.cz;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [CRD-1:0] want, logic [CRD-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // monitor: check each result word and drive ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (cell_expect_q.size() == 0) begin
                    $error("result word with no expected cell: found %0b", o_found);
                    err_cnt++;
                end else begin
                    want_cell = cell_expect_q.pop_front();
                    check_field("found",  CRD'(want_cell.found), CRD'(o_found));
                    check_field("cell_x", want_cell.x, o_cell_x);
                    check_field("cell_y", want_cell.y, o_cell_y);
                    check_field("cell_z", want_cell.z, o_cell_z);
                end
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left   <= hold_left - 1;
            end else if (hold_asked != hold_taken) begin
                hold_taken  <= hold_asked;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CRD-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic set_world(longint lx, longint ly, longint lz,
                             longint hx, longint hy, longint hz, logic [CRD-1:0] lim);
        write_reg(CFG_WMIN_X, CRD'(lx));
        write_reg(CFG_WMIN_Y, CRD'(ly));
        write_reg(CFG_WMIN_Z, CRD'(lz));
        write_reg(CFG_WMAX_X, CRD'(hx));
        write_reg(CFG_WMAX_Y, CRD'(hy));
        write_reg(CFG_WMAX_Z, CRD'(hz));
        write_reg(CFG_RLIMIT, lim);
    endtask

    // wait until every word is taken and every cell has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (walk_req_q.size() != 0 || i_in_valid || cell_expect_q.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic void push_req(logic mode, longint x, longint y, longint z);
        walk_req_q.insert(walk_req_q.size(), {mode, CRD'(x), CRD'(y), CRD'(z)});
    endfunction

    function automatic void push_next();
        push_req(MODE_NEXT, longint'($urandom), longint'($urandom), longint'($urandom));
    endfunction

    function automatic longint pick_in(longint lo, longint hi);
        if (hi < lo)
            return lo;
        return lo + longint'($urandom_range(int'(hi - lo)));
    endfunction

    // mostly restart-then-walk runs; some far restarts and stray next words
    task automatic fill_walks(int n);
        int cnt;
        int k;
        int pick;
        cnt = 0;
        // a few next words first keep an old walk going under the new box
        k = $urandom_range(3);
        repeat (k) push_next();
        cnt += k;
        while (cnt < n) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                push_req(MODE_RESTART, pick_in(box_lo_x, box_hi_x),
                         pick_in(box_lo_y, box_hi_y), pick_in(box_lo_z, box_hi_z));
                k = $urandom_range(40, 1);
                repeat (k) push_next();
                cnt += k + 1;
            end else if (pick < 90) begin
                push_req(MODE_RESTART, longint'($urandom), longint'($urandom),
                         longint'($urandom));
                k = $urandom_range(4);
                repeat (k) push_next();
                cnt += k + 1;
            end else begin
                push_next();
                cnt++;
            end
        end
    endtask

    function automatic longint rand_lo(int span);
        return CRD_MIN + 1 + longint'($urandom_range(int'(CRD_MAX - CRD_MIN - 1) - span));
    endfunction

    task automatic random_setting(int ph, int s);
        longint lo[3];
        longint hi[3];
        logic [CRD-1:0] lim;
        int span;
        lim = CRD'($urandom_range(8));
        for (int a = 0; a < 3; a++) begin
            span = $urandom_range(7);
            case (s)
                0: begin
                    lo[a] = rand_lo(8);
                    hi[a] = lo[a] + span;
                end
                1: begin
                    lo[a] = CRD_MIN;
                    hi[a] = CRD_MIN + (span % 6);
                end
                2: begin
                    hi[a] = CRD_MAX;
                    lo[a] = CRD_MAX - (span % 6);
                end
                default: begin
                    lo[a] = CRD_MIN;
                    hi[a] = CRD_MAX;
                end
            endcase
        end
        // an empty x range now and then
        if (s == 0 && $urandom_range(7) == 0)
            hi[0] = lo[0] - 1;
        if (s == 3)
            lim = (ph == 0) ? CRD'(0) : (ph == 1) ? CRD'(CRD_MAX) : CRD'($urandom_range(3));
        // top bit lies above the limit field and must be dropped
        lim[CRD-1] = 1'($urandom_range(1));
        set_world(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], lim);
    endtask

    initial begin
        reset_walker();
        send_idle_pct = 21;
        recv_idle_pct = 70;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-cell world after reset: next before restart, one cell, then covered
        push_next();
        push_req(MODE_RESTART, 0, 0, 0);
        push_next();
        push_next();
        wait_idle();

        // small box; the spare index must change nothing
        write_reg(CFG_IDX_SPARE, CRD'(CRD_MAX));
        set_world(-2, -1, 0, 2, 1, 3, CRD'(1));
        @(negedge i_clk);
        push_req(MODE_RESTART, 3, 0, 0);
        push_next();
        push_req(MODE_RESTART, 0, 0, 0);
        repeat (10) push_next();
        wait_idle();

        // full coordinate range, limit 0 written with the spare top bit set
        set_world(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
                  CRD'(1) << (CRD - 1));
        @(negedge i_clk);
        push_req(MODE_RESTART, CRD_MIN, CRD_MAX, CRD_MIN);
        push_next();
        push_next();
        push_req(MODE_RESTART, CRD_MAX, CRD_MIN, CRD_MAX);
        push_next();
        push_next();

        for (int ph = 0; ph < 3; ph++) begin
            for (int s = 0; s < 4; s++) begin
                wait_idle();
                send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 70 : 0;
                recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 21 : 0;
                random_setting(ph, s);
                @(negedge i_clk);
                fill_walks(WORDS_PER_SETTING);
                // long receiver hold-off while the sender keeps offering
                if (ph == 2 && s == 0)
                    hold_asked++;
            end
        end

        wait_idle();
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
